/* src/tlpt_pkg.sv */
package tlpt_pkg;

	// Size of the table pool. TBL_W, NF_W, TBL_DEPTH, TADDR_W and DIR_W follow from it.
	localparam int NUM_TABLES = 8;

	localparam int DIR_ENTRIES = 1024;
	localparam int TBL_ENTRIES = 1024;
	localparam int IDX_W       = $clog2(DIR_ENTRIES);
	localparam int TBL_W       = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
	localparam int NF_W        = $clog2(NUM_TABLES + 1);
	localparam int TBL_DEPTH   = NUM_TABLES * TBL_ENTRIES;
	localparam int TADDR_W     = $clog2(TBL_DEPTH);
	localparam int DIR_W       = TBL_W + 1;

	localparam int ADDR_W   = 32;
	localparam int OFS_W    = 12;
	localparam int FRAME_W  = ADDR_W - OFS_W;
	localparam int PTE_W    = FRAME_W + 1;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;

	localparam logic [FUNC_W-1:0] FN_MAP   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_UNMAP = 2'd1;
	localparam logic [FUNC_W-1:0] FN_XLATE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FAULT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOTBL = 2'd2;

	typedef struct packed {
		logic                capture;
		logic                dir_rd;
		logic                dir_clr_wr;
		logic                dir_link_wr;
		logic                tbl_rd;
		logic                tbl_clr_wr;
		logic                pte_wr;
		logic                pte_new;
		logic                clr_inc;
		logic                alloc_inc;
		logic                out_load;
		logic                out_from_pte;
		logic [STATUS_W-1:0] out_status;
	} tlpt_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              dir_present;
		logic              pool_full;
		logic              clr_last;
		logic              out_busy;
	} tlpt_sts_t;

endpackage

/* src/tlpt_dp.sv */
module tlpt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tlpt_pkg::tlpt_cmd_t           cmd,
	output tlpt_pkg::tlpt_sts_t           sts,
	input  logic [tlpt_pkg::FUNC_W-1:0]   func,
	input  logic [tlpt_pkg::ADDR_W-1:0]   virt_addr,
	input  logic [tlpt_pkg::ADDR_W-1:0]   phys_addr,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tlpt_pkg::ADDR_W-1:0]   phys_result,
	output logic [tlpt_pkg::STATUS_W-1:0] status
);
	import tlpt_pkg::*;

	logic [DIR_W-1:0]   dir_mem [0:DIR_ENTRIES-1];
	logic [PTE_W-1:0]   tbl_mem [0:TBL_DEPTH-1];

	logic [FUNC_W-1:0]   func_q;
	logic [ADDR_W-1:0]   va_q;
	logic [FRAME_W-1:0]  pa_frame_q;
	logic [DIR_W-1:0]    dir_rdata_q;
	logic [PTE_W-1:0]    pte_q;
	logic [IDX_W-1:0]    clr_q;
	logic [NF_W-1:0]     next_free_q;
	logic                out_valid_q;
	logic [ADDR_W-1:0]   phys_result_q;
	logic [STATUS_W-1:0] status_q;

	logic [IDX_W-1:0]   dir_idx;
	logic [IDX_W-1:0]   tbl_idx;
	logic [TBL_W-1:0]   dir_tbl;
	logic [TBL_W-1:0]   alloc_tbl;
	logic [TBL_W-1:0]   pte_tbl;
	logic [TADDR_W-1:0] clr_addr;
	logic [TADDR_W-1:0] pte_addr;
	logic [TADDR_W-1:0] rd_addr;
	logic [PTE_W-1:0]   pte_wdata;
	logic               pte_present;

	assign dir_idx   = va_q[ADDR_W-1 -: IDX_W];
	assign tbl_idx   = va_q[OFS_W +: IDX_W];
	assign dir_tbl   = dir_rdata_q[DIR_W-1:1];
	assign alloc_tbl = TBL_W'(next_free_q);
	assign pte_tbl   = cmd.pte_new ? alloc_tbl : dir_tbl;
	assign clr_addr  = TADDR_W'({alloc_tbl, clr_q});
	assign pte_addr  = TADDR_W'({pte_tbl, tbl_idx});
	assign rd_addr   = TADDR_W'({dir_tbl, tbl_idx});
	// A map writes the frame with the present bit; an unmap writes an empty entry.
	assign pte_wdata = (func_q == FN_MAP) ? {pa_frame_q, 1'b1} : '0;
	assign pte_present = pte_q[0];

	assign sts.func        = func_q;
	assign sts.dir_present = dir_rdata_q[0];
	assign sts.pool_full   = (next_free_q == NF_W'(NUM_TABLES));
	assign sts.clr_last    = (clr_q == IDX_W'(DIR_ENTRIES - 1));
	assign sts.out_busy    = out_valid_q && out_stall;

	assign out_valid   = out_valid_q;
	assign phys_result = phys_result_q;
	assign status      = status_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q     <= func;
			va_q       <= virt_addr;
			pa_frame_q <= phys_addr[ADDR_W-1:OFS_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dir_clr_wr) begin
			dir_mem[clr_q] <= '0;
		end else if (cmd.dir_link_wr) begin
			dir_mem[dir_idx] <= {alloc_tbl, 1'b1};
		end
		if (cmd.dir_rd) begin
			dir_rdata_q <= dir_mem[dir_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tbl_clr_wr) begin
			tbl_mem[clr_addr] <= '0;
		end else if (cmd.pte_wr) begin
			tbl_mem[pte_addr] <= pte_wdata;
		end
		if (cmd.tbl_rd) begin
			pte_q <= tbl_mem[rd_addr];
		end
	end

	// The sweep counter wraps to zero at the end of every pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			next_free_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_inc) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.alloc_inc) begin
				next_free_q <= next_free_q + NF_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_from_pte) begin
				phys_result_q <= pte_present ? {pte_q[PTE_W-1:1], va_q[OFS_W-1:0]} : '0;
				status_q      <= pte_present ? ST_OK : ST_FAULT;
			end else begin
				phys_result_q <= '0;
				status_q      <= cmd.out_status;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result loaded over one that is still waiting");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= NF_W'(NUM_TABLES))
		else $error("table pool count beyond its size");

	a_result_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && phys_result_q != '0) |-> status_q == ST_OK)
		else $error("non-zero address with a failing status");

endmodule

/* src/tlpt_ctrl.sv */
module tlpt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tlpt_pkg::tlpt_sts_t sts,
	output tlpt_pkg::tlpt_cmd_t cmd
);
	import tlpt_pkg::*;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_DIR,
		S_DECIDE,
		S_CLEAR,
		S_LINK,
		S_TBL,
		S_RESP
	} state_t;

	state_t              state_q;
	state_t              state_d;
	logic [STATUS_W-1:0] resp_code_q;
	logic [STATUS_W-1:0] resp_code_d;
	logic                resp_pte_q;
	logic                resp_pte_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		resp_code_d = resp_code_q;
		resp_pte_d  = resp_pte_q;
		cmd.out_status   = resp_code_q;
		cmd.out_from_pte = resp_pte_q;
		unique case (state_q)
			S_INIT: begin
				// Directory sweep after reset: every entry becomes not present.
				cmd.dir_clr_wr = 1'b1;
				cmd.clr_inc    = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_DIR;
				end
			end
			S_DIR: begin
				cmd.dir_rd = 1'b1;
				state_d    = S_DECIDE;
			end
			S_DECIDE: begin
				resp_code_d = ST_OK;
				resp_pte_d  = 1'b0;
				state_d     = S_RESP;
				case (sts.func)
					FN_MAP: begin
						if (sts.dir_present) begin
							cmd.pte_wr = 1'b1;
						end else if (sts.pool_full) begin
							resp_code_d = ST_NOTBL;
						end else begin
							state_d = S_CLEAR;
						end
					end
					FN_UNMAP: begin
						cmd.pte_wr = sts.dir_present;
					end
					FN_XLATE: begin
						if (sts.dir_present) begin
							state_d = S_TBL;
						end else begin
							resp_code_d = ST_FAULT;
						end
					end
					default: begin
						resp_code_d = ST_OK;
					end
				endcase
			end
			S_CLEAR: begin
				cmd.tbl_clr_wr = 1'b1;
				cmd.clr_inc    = 1'b1;
				if (sts.clr_last) begin
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				cmd.dir_link_wr = 1'b1;
				cmd.pte_wr      = 1'b1;
				cmd.pte_new     = 1'b1;
				cmd.alloc_inc   = 1'b1;
				resp_code_d     = ST_OK;
				resp_pte_d      = 1'b0;
				state_d         = S_RESP;
			end
			S_TBL: begin
				cmd.tbl_rd = 1'b1;
				resp_pte_d = 1'b1;
				state_d    = S_RESP;
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			resp_code_q <= ST_OK;
			resp_pte_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			resp_code_q <= resp_code_d;
			resp_pte_q  <= resp_pte_d;
		end
	end

	a_link_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dir_link_wr |-> !sts.pool_full)
		else $error("directory linked with the table pool exhausted");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second request taken while one is in progress");

endmodule

/* src/two_level_page_table_engine_unit.sv */
// Channel   Handshake             Payload
// request   in_valid / in_stall   func, virt_addr, phys_addr
// result    out_valid / out_stall phys_result, status
//
// One request at a time. Map and unmap pass through S_DIR, S_DECIDE and S_RESP
// between acceptances and read the directory once. Translate adds S_TBL, as its
// table read depends on the directory read.
// A map that allocates a table first sweeps its 1024 entries.
// After reset the directory is swept with in_stall high.
// A new request is taken while a result waits in the output register; the
// following result holds until out_stall lets that one go.
module two_level_page_table_engine_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tlpt_pkg::FUNC_W-1:0]   func,
	input  logic [tlpt_pkg::ADDR_W-1:0]   virt_addr,
	input  logic [tlpt_pkg::ADDR_W-1:0]   phys_addr,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tlpt_pkg::ADDR_W-1:0]   phys_result,
	output logic [tlpt_pkg::STATUS_W-1:0] status
);
	import tlpt_pkg::*;

	tlpt_cmd_t cmd;
	tlpt_sts_t sts;

	tlpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tlpt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.virt_addr   (virt_addr),
		.phys_addr   (phys_addr),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.phys_result (phys_result),
		.status      (status)
	);

endmodule

/* tb/tb_two_level_page_table_engine_unit.sv */
`timescale 1ns / 100ps

module tb_two_level_page_table_engine_unit;
	import tlpt_pkg::*;

	localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;
	localparam int RANDOM_REQUESTS = 700;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int TAIL_CYCLES     = 16;

	typedef struct packed {
		logic [FUNC_W-1:0] op;
		logic [ADDR_W-1:0] va;
		logic [ADDR_W-1:0] pa;
		logic              drain_first;
	} page_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   phys;
		logic [STATUS_W-1:0] st;
	} page_resp_t;

	typedef struct packed {
		logic [TBL_W-1:0] tbl;
		logic             present;
	} dir_ent_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               present;
	} pte_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [FUNC_W-1:0]   func      = FN_MAP;
	logic [ADDR_W-1:0]   virt_addr = '0;
	logic [ADDR_W-1:0]   phys_addr = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [ADDR_W-1:0]   phys_result;
	logic [STATUS_W-1:0] status;

	// Shadow copy of the directory, the table pool and the allocation count.
	dir_ent_t shadow_dir [DIR_ENTRIES];
	pte_t     shadow_pte [TBL_DEPTH];
	int       tables_taken;

	page_req_t  request_backlog [$];
	page_resp_t due_results [$];

	int request_total;
	int issued;
	int results_seen;
	int failures;
	int quiet_cycles;
	int n_map, n_unmap, n_xlate, n_spare, n_fault, n_exhausted;

	two_level_page_table_engine_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.virt_addr   (virt_addr),
		.phys_addr   (phys_addr),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.phys_result (phys_result),
		.status      (status)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void walk_tables(input logic [FUNC_W-1:0] op,
			input logic [ADDR_W-1:0] va, input logic [ADDR_W-1:0] pa,
			output page_resp_t ans);
		logic [IDX_W-1:0] di;
		logic [IDX_W-1:0] ti;
		dir_ent_t         de;
		pte_t             pte;
		int unsigned      tb;
		logic             linked;
		di = va[OFS_W+IDX_W +: IDX_W];
		ti = va[OFS_W +: IDX_W];
		de = shadow_dir[di];
		tb = 32'(de.tbl);
		linked = de.present && (tb < NUM_TABLES);
		ans.phys = '0;
		ans.st = ST_OK;
		case (op)
		FN_MAP: begin
			n_map++;
			if (!linked) begin
				if (tables_taken < NUM_TABLES) begin
					tb = tables_taken;
					tables_taken++;
					for (int k = 0; k < TBL_ENTRIES; k++)
						shadow_pte[tb*TBL_ENTRIES + k] = '0;
					de.tbl = tb[TBL_W-1:0];
					de.present = 1'b1;
					shadow_dir[di] = de;
					linked = 1'b1;
				end else begin
					ans.st = ST_NOTBL;
					n_exhausted++;
				end
			end
			if (linked) begin
				pte.frame = pa[ADDR_W-1:OFS_W];
				pte.present = 1'b1;
				shadow_pte[tb*TBL_ENTRIES + ti] = pte;
			end
		end
		FN_UNMAP: begin
			n_unmap++;
			if (linked)
				shadow_pte[tb*TBL_ENTRIES + ti] = '0;
		end
		FN_XLATE: begin
			n_xlate++;
			if (linked)
				pte = shadow_pte[tb*TBL_ENTRIES + ti];
			else
				pte = '0;
			if (pte.present) begin
				ans.phys = {pte.frame, va[OFS_W-1:0]};
			end else begin
				ans.st = ST_FAULT;
				n_fault++;
			end
		end
		default: n_spare++;
		endcase
	endfunction

	function automatic int idle_phase();
		int p;
		p = (request_total == 0) ? 2 : issued * 3 / request_total;
		return (p > 2) ? 2 : p;
	endfunction

	function automatic int sender_gap_pct();
		case (idle_phase())
		0: return 28;
		1: return 61;
		default: return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct();
		case (idle_phase())
		0: return 61;
		1: return 28;
		default: return 0;
		endcase
	endfunction

	task automatic queue_request(input logic [FUNC_W-1:0] op, input logic [ADDR_W-1:0] va,
			input logic [ADDR_W-1:0] pa, input logic drain_first);
		page_req_t r;
		r.op = op;
		r.va = va;
		r.pa = pa;
		r.drain_first = drain_first;
		request_backlog.push_back(r);
	endtask

	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned hot_dirs [11] = '{0, 1023, 2, 3, 4, 5, 6, 7, 8, 9, 512};
		logic [IDX_W-1:0] di;
		logic [IDX_W-1:0] ti;
		// Mostly linked directory slots and a few table slots, so that
		// translations and unmaps meet mappings made earlier.
		if ($urandom_range(0, 99) < 85)
			di = IDX_W'(hot_dirs[$urandom_range(0, 10)]);
		else
			di = IDX_W'($urandom_range(0, DIR_ENTRIES - 1));
		if ($urandom_range(0, 99) < 80)
			ti = IDX_W'($urandom_range(0, 15));
		else
			ti = IDX_W'($urandom_range(0, TBL_ENTRIES - 1));
		return {di, ti, 12'($urandom_range(0, 4095))};
	endfunction

	always @(posedge clk) begin : drive_requests
		page_req_t  nxt;
		page_resp_t want;
		logic       go;
		if (arst_n) begin
			go = in_valid;
			if (in_valid && !in_stall) begin
				walk_tables(func, virt_addr, phys_addr, want);
				due_results.push_back(want);
				go = 1'b0;
			end
			if (!go && request_backlog.size() > 0
					&& !(request_backlog[0].drain_first && due_results.size() > 0)
					&& $urandom_range(0, 99) >= sender_gap_pct()) begin
				nxt = request_backlog.pop_front();
				func <= nxt.op;
				virt_addr <= nxt.va;
				phys_addr <= nxt.pa;
				issued++;
				go = 1'b1;
			end
			in_valid <= go;
		end
	end

	always @(posedge clk) begin : check_results
		page_resp_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (due_results.size() == 0) begin
					$display("%0t: result with none outstanding: phys_result=%h status=%0d",
						$time, phys_result, status);
					failures++;
				end else begin
					want = due_results.pop_front();
					if (phys_result !== want.phys) begin
						$display("%0t: phys_result expected %h actual %h",
							$time, want.phys, phys_result);
						failures++;
					end
					if (status !== want.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.st, status);
						failures++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
			$display("two_level_page_table_engine_unit regression: fail");
			$finish;
		end
	end

	initial begin : run_test
		int          n_directed;
		int          idx;
		int unsigned roll;
		logic [FUNC_W-1:0] op;

		for (int k = 0; k < DIR_ENTRIES; k++)
			shadow_dir[k] = '0;
		for (int k = 0; k < TBL_DEPTH; k++)
			shadow_pte[k] = '0;
		tables_taken = 0;

		// Empty directory: translation faults and unmap is harmless; then the first and last pages are mapped.
		queue_request(FN_XLATE, 32'h0000_0000, 32'h0, 1'b0);
		queue_request(FN_UNMAP, 32'hFFFF_FFFF, 32'h0, 1'b0);
		queue_request(FN_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		queue_request(FN_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		queue_request(FN_XLATE, 32'h0000_0FFF, 32'h0, 1'b0);
		queue_request(FN_MAP,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
		queue_request(FN_XLATE, 32'hFFFF_F000, 32'hFFFF_FFFF, 1'b0);
		queue_request(FN_XLATE, 32'h0000_1000, 32'h0, 1'b0);
		// Overwrite a present entry, then take it away again.
		queue_request(FN_MAP,   32'h0000_0123, 32'h1234_5678, 1'b0);
		queue_request(FN_XLATE, 32'h0000_0ABC, 32'h0, 1'b0);
		queue_request(FN_UNMAP, 32'h0000_0000, 32'h0, 1'b0);
		queue_request(FN_XLATE, 32'h0000_0000, 32'h0, 1'b0);
		queue_request(FN_UNMAP, 32'h0000_0000, 32'h0, 1'b0);
		queue_request(FN_SPARE, 32'h0000_0000, 32'h0000_0000, 1'b0);
		// Use up the rest of the pool, then ask for one table more.
		for (int d = 2; d < 8; d++)
			queue_request(FN_MAP, {10'(d), 10'(d), 12'h5A5}, $urandom, 1'b0);
		queue_request(FN_MAP,   {10'd8, 10'd1, 12'h000}, 32'hCAFE_F00D, 1'b0);
		queue_request(FN_XLATE, {10'd8, 10'd1, 12'h000}, 32'h0, 1'b0);
		queue_request(FN_UNMAP, {10'd8, 10'd1, 12'h000}, 32'h0, 1'b0);

		n_directed = request_backlog.size();
		request_total = n_directed + RANDOM_REQUESTS;
		for (int k = 0; k < RANDOM_REQUESTS; k++) begin
			idx = n_directed + k;
			roll = $urandom_range(0, 99);
			if (roll < 35)
				op = FN_MAP;
			else if (roll < 55)
				op = FN_UNMAP;
			else if (roll < 95)
				op = FN_XLATE;
			else
				op = FN_SPARE;
			// The sender holds back at the start of the random part and at each
			// change of idling pattern until every answer has come back.
			queue_request(op, pick_address(), $urandom,
				idx == n_directed || idx == request_total / 3
				|| idx == 2 * request_total / 3);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (request_backlog.size() > 0 || in_valid || due_results.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d requests (%0d map, %0d unmap, %0d translate, %0d unused code), %0d results",
			issued, n_map, n_unmap, n_xlate, n_spare, results_seen);
		$display("%0d translation faults, %0d maps refused with the pool used up, %0d tables taken",
			n_fault, n_exhausted, tables_taken);
		if (due_results.size() > 0) begin
			$display("%0t: %0d expected results never arrived", $time, due_results.size());
			failures++;
		end
		if (failures == 0) begin
			$display("two_level_page_table_engine_unit regression: pass");
		end else begin
			$display("two_level_page_table_engine_unit regression: fail");
		end
		$finish;
	end

endmodule
